// ----- src/rws_pkg.sv -----
// Shared constants, codes and control structs for the roulette wheel selector.
// Used by the controller, datapath, checker and top level; no dependencies.
package rws_pkg;

    localparam int POP_MAX   = 64;
    localparam int FIT_BITS  = 16;
    localparam int IDX_W     = $clog2(POP_MAX);
    localparam int TOTAL_W   = FIT_BITS + IDX_W;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = FRAC_W + TOTAL_W;
    localparam int CFG_W     = 7;
    localparam int CFG_RESET = 64;
    localparam int ENTRY_W   = 6;
    localparam int FITIN_W   = 16;
    localparam int SEL_W     = 6;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    typedef enum logic
    {
        CMD_WRITE  = 1'b0,
        CMD_SELECT = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic load_in;
        logic wr_commit;
        logic mul_start;
        logic walk_step;
        logic push_out;
    } dp_cmd_t;

    typedef struct packed
    {
        logic walk_done;
        logic out_free;
    } dp_status_t;

endpackage

// ----- src/roulette_wheel_selector_core.sv -----
// Top level of the roulette wheel selector: stream ports, config port, ctrl and datapath.
// Depends on rws_pkg, rws_ctrl, rws_dp (and rws_ram through the datapath).
//
//  channel   direction  words carried
//  s_axis    in         write fitness entry (tuser=0) or select (tuser=1)
//  m_axis    out        one selected member per select word
//  cfg       in         population_size, single register, write only
//
// A write word reads the old entry from the table, then updates the total and writes the entry.
// A select word runs the fraction*total multiply, then walks k = 1..POP_MAX entries with
// one table read per entry through the RAM read port, then pushes the result. Reset clears
// the table valid bits and the total and sets the config to CFG_RESET at once. A stalled
// output holds the next select in its push step only.
module roulette_wheel_selector_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [5:0] entry_index, [21:6] fitness_value, [37:22] random_fraction, [39:38] zero
    input  logic [rws_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] command
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [5:0] selected_index, [7:6] zero
    output logic [rws_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [0] fell_through
    output logic                          m_axis_tuser,
    input  logic                          cfg_we,
    input  logic [rws_pkg::CFG_W-1:0]     cfg_wdata
);

    rws_pkg::dp_cmd_t             cmd;
    rws_pkg::dp_status_t          status;
    logic [rws_pkg::SEL_W-1:0]    selected_index;

    rws_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_axis_tvalid),
        .in_kind (s_axis_tuser),
        .in_ready(s_axis_tready),
        .cmd     (cmd),
        .status  (status)
    );

    rws_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .entry_index    (s_axis_tdata[5:0]),
        .fitness_value  (s_axis_tdata[21:6]),
        .random_fraction(s_axis_tdata[37:22]),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .selected_index (selected_index),
        .fell_through   (m_axis_tuser)
    );

    assign m_axis_tdata = {{(rws_pkg::M_TDATA_W - rws_pkg::SEL_W){1'b0}}, selected_index};

endmodule

// ----- src/rws_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/rws_ctrl.sv -----
// Sequencer for write and select words of the roulette wheel selector.
// Depends on rws_pkg for the command and status structs.
module rws_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_kind,
    output logic                in_ready,
    output rws_pkg::dp_cmd_t    cmd,
    input  rws_pkg::dp_status_t status
);

    typedef enum logic [4:0]
    {
        ST_IDLE = 5'b00001,
        ST_WR   = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_WALK = 5'b01000,
        ST_PUSH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = (in_kind == rws_pkg::CMD_SELECT) ? ST_MUL : ST_WR;
                end
            end
            ST_WR:
            begin
                cmd.wr_commit = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_MUL:
            begin
                cmd.mul_start = 1'b1;
                state_next    = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_done)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                // hold the pick until the output register frees up
                if (status.out_free)
                begin
                    cmd.push_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/rws_dp.sv -----
// Datapath: fitness table, running total, target multiply, walk and output register.
// Depends on rws_pkg and rws_ram.
module rws_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [rws_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic [rws_pkg::ENTRY_W-1:0]  entry_index,
    input  logic [rws_pkg::FITIN_W-1:0]  fitness_value,
    input  logic [rws_pkg::FRAC_W-1:0]   random_fraction,
    input  rws_pkg::dp_cmd_t             cmd,
    output rws_pkg::dp_status_t          status,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [rws_pkg::SEL_W-1:0]    selected_index,
    output logic                         fell_through
);

    localparam int IDX_W   = rws_pkg::IDX_W;
    localparam int TOTAL_W = rws_pkg::TOTAL_W;
    localparam int FIT_W   = rws_pkg::FIT_BITS;

    logic [rws_pkg::CFG_W-1:0]  pop_reg;
    logic [IDX_W-1:0]           last_reg;
    logic [FIT_W-1:0]           fit_reg;
    logic [rws_pkg::FRAC_W-1:0] frac_reg;
    logic [IDX_W-1:0]           wr_addr_reg;
    logic                       in_range_reg;
    logic [TOTAL_W-1:0]         total_reg;
    logic [rws_pkg::POP_MAX-1:0] valid_reg;
    logic                       rd_valid_reg;
    logic [TOTAL_W-1:0]         target_reg;
    logic [TOTAL_W-1:0]         acc_reg;
    logic [IDX_W-1:0]           walk_idx_reg;
    logic [IDX_W-1:0]           pick_reg;
    logic                       fell_reg;
    logic                       out_valid_reg;
    logic [rws_pkg::SEL_W-1:0]  out_index_reg;
    logic                       out_fell_reg;

    logic [31:0]                pop32;
    logic [31:0]                idx32;
    logic [31:0]                fit32;
    logic [31:0]                pick32;
    logic [IDX_W-1:0]           last_calc;
    logic [IDX_W-1:0]           raddr;
    logic [FIT_W-1:0]           rdata;
    logic [FIT_W-1:0]           entry_fit;
    logic [TOTAL_W-1:0]         sum;
    logic [rws_pkg::PROD_W-1:0] product;
    logic                       hit;
    logic                       at_last;

    assign pop32  = 32'(pop_reg);
    assign idx32  = 32'(entry_index);
    assign fit32  = 32'(fitness_value);
    assign pick32 = 32'(pick_reg);

    // clamp the population size to 1..POP_MAX and keep the last member index
    always_comb
    begin
        if (pop32 == 32'd0)
        begin
            last_calc = '0;
        end
        else if (pop32 > 32'(rws_pkg::POP_MAX))
        begin
            last_calc = IDX_W'(rws_pkg::POP_MAX - 1);
        end
        else
        begin
            last_calc = IDX_W'(pop32 - 32'd1);
        end
    end

    always_comb
    begin
        if (cmd.load_in)
        begin
            raddr = idx32[IDX_W-1:0];
        end
        else if (cmd.mul_start)
        begin
            raddr = '0;
        end
        else
        begin
            raddr = walk_idx_reg + IDX_W'(1);
        end
    end

    rws_ram #(
        .WIDTH(FIT_W),
        .DEPTH(rws_pkg::POP_MAX)
    ) u_table (
        .clk  (clk),
        .we   (cmd.wr_commit & in_range_reg),
        .waddr(wr_addr_reg),
        .wdata(fit_reg),
        .raddr(raddr),
        .rdata(rdata)
    );

    // never-written entries read as zero
    assign entry_fit = rd_valid_reg ? rdata : '0;
    assign sum       = acc_reg + TOTAL_W'(entry_fit);
    assign hit       = (sum >= target_reg);
    assign at_last   = (walk_idx_reg == last_reg);
    assign product   = frac_reg * total_reg;

    assign status.walk_done = hit | at_last;
    assign status.out_free  = ~out_valid_reg | out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_reg       <= rws_pkg::CFG_W'(rws_pkg::CFG_RESET);
            total_reg     <= '0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pop_reg <= cfg_wdata;
            end
            rd_valid_reg <= valid_reg[raddr];
            if (cmd.wr_commit && in_range_reg)
            begin
                total_reg              <= total_reg - TOTAL_W'(entry_fit) + TOTAL_W'(fit_reg);
                valid_reg[wr_addr_reg] <= 1'b1;
            end
            if (cmd.push_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            fit_reg      <= fit32[FIT_W-1:0];
            frac_reg     <= random_fraction;
            wr_addr_reg  <= idx32[IDX_W-1:0];
            in_range_reg <= (idx32 < 32'(rws_pkg::POP_MAX));
            last_reg     <= last_calc;
        end
        if (cmd.mul_start)
        begin
            target_reg   <= product[rws_pkg::PROD_W-1:rws_pkg::FRAC_W];
            acc_reg      <= '0;
            walk_idx_reg <= '0;
        end
        else if (cmd.walk_step)
        begin
            if (hit || at_last)
            begin
                pick_reg <= walk_idx_reg;
                fell_reg <= ~hit;
            end
            else
            begin
                acc_reg      <= sum;
                walk_idx_reg <= walk_idx_reg + IDX_W'(1);
            end
        end
        if (cmd.push_out)
        begin
            out_index_reg <= pick32[rws_pkg::SEL_W-1:0];
            out_fell_reg  <= fell_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign selected_index = out_index_reg;
    assign fell_through   = out_fell_reg;

endmodule

// ----- src/rws_checker.sv -----
// Port-level checks for roulette_wheel_selector_core, attached by bind.
// Depends on rws_pkg for widths and the population bound.
module rws_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [rws_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser,
    input logic                          cfg_we,
    input logic [rws_pkg::CFG_W-1:0]     cfg_wdata
);

    logic [rws_pkg::CFG_W-1:0] pop_reg;
    logic [31:0]               pop32;
    logic [31:0]               last32;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_reg <= rws_pkg::CFG_W'(rws_pkg::CFG_RESET);
        end
        else if (cfg_we)
        begin
            pop_reg <= cfg_wdata;
        end
    end

    assign pop32  = 32'(pop_reg);
    assign last32 = (pop32 == 32'd0) ? 32'd0 :
                    (pop32 > 32'(rws_pkg::POP_MAX)) ? 32'(rws_pkg::POP_MAX - 1) :
                    pop32 - 32'd1;

    // a result stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped before it was taken");

    // every accepted word keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after a word");

    // a walk that runs out returns the last member taking part
    a_fall_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> 32'(m_axis_tdata[5:0]) == last32)
        else $error("fell-through pick is not the last member");

    // a select result never picks beyond the population
    a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> 32'(m_axis_tdata[5:0]) <= last32)
        else $error("pick beyond the population");

endmodule

bind roulette_wheel_selector_core rws_checker u_rws_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
);
